// File: rtl/rlr_pkg.sv
package rlr_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned CountWidth = 6;
   localparam int unsigned StepWidth = 5;

   typedef logic [DataWidth-1:0] word_type;

   localparam word_type LcgMult = 32'd1664525;
   localparam word_type LcgInc = 32'd1013904223;
   localparam word_type LcgSeed = 32'd42;

   localparam logic [CountWidth-1:0] MulSteps = 6'd32;
   localparam logic [StepWidth-1:0] DivLast = 5'd31;

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StDiv = 2'd1;
   localparam logic [1:0] StFin = 2'd2;

endpackage

// File: rtl/ranged_lcg_random.sv
// Bounded pseudo-random number generator.
//
// Input channel req_*: one transfer carries range_low (tdata[31:0]) and
// range_high (tdata[63:32]). Output channel rsp_*: one transfer per request
// carries random_value in [range_low, range_high), or range_low when
// range_low >= range_high (the generator then does not advance).
//
// A 32-bit LCG (x = 1664525 * x + 1013904223) is advanced by a bit-serial
// shift-add multiplier that runs ahead of use: the next state is ready
// before it is asked for. The reduction modulo the span is a restoring
// divider that retires one quotient bit per cycle.
//
// No new request is taken until the last one has passed through the
// divider steps and the finishing state, which forms the result; an empty
// range skips the divider and goes straight to the finishing state.
// After reset the multiplier forms the first state from seed 42, and
// req_tready stays low until then.
// The result sits in an output register; a new request is taken while it
// waits. If the receiver stalls, the next result holds in the divider until
// the register is free.
module ranged_lcg_random
   import rlr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] range_low, [63:32] range_high
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] random_value
);

   word_type              range_low;
   word_type              range_high;
   logic                  req_xfer;
   logic                  empty_range;
   logic                  out_free;

   logic [1:0]            state_ff, state_in;
   word_type              lo_ff, lo_in;
   word_type              span_ff, span_in;
   word_type              rem_ff, rem_in;
   word_type              quo_ff, quo_in;
   logic [StepWidth-1:0]  dcnt_ff, dcnt_in;
   logic [DataWidth:0]    trial;
   logic [DataWidth:0]    trial_sub;

   logic                  mbusy_ff, mbusy_in;
   logic [CountWidth-1:0] mcnt_ff, mcnt_in;
   word_type              mop_ff, mop_in;
   word_type              mcnd_ff, mcnd_in;
   word_type              macc_ff, macc_in;
   word_type              nxt_ff, nxt_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   word_type              rsp_data_ff, rsp_data_in;

   assign range_low   = req_tdata[31:0];
   assign range_high  = req_tdata[63:32];
   assign req_tready  = (state_ff == StIdle) && !mbusy_ff;
   assign req_xfer    = req_tvalid && req_tready;
   assign empty_range = range_low >= range_high;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;

   assign trial     = {rem_ff, quo_ff[DataWidth-1]};
   assign trial_sub = trial - {1'b0, span_ff};

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      span_in      = span_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      mbusy_in     = mbusy_ff;
      mcnt_in      = mcnt_ff;
      mop_in       = mop_ff;
      mcnd_in      = mcnd_ff;
      macc_in      = macc_ff;
      nxt_in       = nxt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (mbusy_ff) begin
         if (mcnt_ff == MulSteps) begin
            nxt_in   = macc_ff + LcgInc;
            mbusy_in = 1'b0;
         end else begin
            if (mop_ff[0]) begin
               macc_in = macc_ff + mcnd_ff;
            end
            mop_in  = mop_ff >> 1;
            mcnd_in = mcnd_ff << 1;
            mcnt_in = mcnt_ff + 1'b1;
         end
      end

      case (state_ff)
         StIdle: begin
            if (req_xfer) begin
               lo_in   = range_low;
               span_in = range_high - range_low;
               rem_in  = '0;
               quo_in  = nxt_ff;
               dcnt_in = '0;
               if (empty_range) begin
                  state_in = StFin;
               end else begin
                  state_in = StDiv;
                  mop_in   = nxt_ff;
                  mcnd_in  = LcgMult;
                  macc_in  = '0;
                  mcnt_in  = '0;
                  mbusy_in = 1'b1;
               end
            end
         end
         StDiv: begin
            if (!trial_sub[DataWidth]) begin
               rem_in = trial_sub[DataWidth-1:0];
            end else begin
               rem_in = trial[DataWidth-1:0];
            end
            quo_in  = quo_ff << 1;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DivLast) begin
               state_in = StFin;
            end
         end
         StFin: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rem_ff + lo_ff;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         mbusy_ff     <= 1'b1;
         mcnt_ff      <= '0;
         mop_ff       <= LcgSeed;
         mcnd_ff      <= LcgMult;
         macc_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mbusy_ff     <= mbusy_in;
         mcnt_ff      <= mcnt_in;
         mop_ff       <= mop_in;
         mcnd_ff      <= mcnd_in;
         macc_ff      <= macc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      span_ff     <= span_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dcnt_ff     <= dcnt_in;
      nxt_ff      <= nxt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff != StIdle)
      else $error("request transfer did not start work");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StFin) && out_free |=> rsp_tvalid)
      else $error("finished result not presented");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == StDiv |-> rem_ff < span_ff)
      else $error("partial remainder not below span");

   assert property (@(posedge clock) disable iff (reset)
      mbusy_ff |-> mcnt_ff <= MulSteps)
      else $error("multiplier step count overran");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == StDiv |-> mbusy_ff || (dcnt_ff != '0))
      else $error("next state not in progress during division");

endmodule

// File: tb/tb_ranged_lcg_random.sv
`timescale 1ns / 1ps

module tb_ranged_lcg_random
   import rlr_pkg::*;
();

   localparam int unsigned StallLimit = 4000;
   localparam int unsigned DrainCycles = 40;
   localparam int unsigned RandomItems = 1200;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // [31:0] range_low, [63:32] range_high
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] random_value

   word_type    lcg_state;
   word_type    expected_values[$];
   bit          idle_on;
   int unsigned error_count;
   int unsigned sent_count;
   int unsigned empty_count;
   int unsigned checked_count;
   int unsigned quiet_cycles;

   ranged_lcg_random u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic word_type next_random_value(word_type lo, word_type hi);
      word_type span;
      if (lo >= hi) begin
         return lo;
      end
      lcg_state = lcg_state * LcgMult + LcgInc;
      span = hi - lo;
      return lcg_state % span + lo;
   endfunction

   task automatic send_range(input word_type lo, input word_type hi);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {hi, lo};
      do @(posedge clock); while (!req_tready);
      if (lo >= hi) begin
         empty_count++;
      end
      expected_values.push_back(next_random_value(lo, hi));
      sent_count++;
   endtask

   task automatic pick_range(output word_type lo, output word_type hi);
      int unsigned kind;
      word_type    span;
      kind = $urandom_range(99);
      if (kind < 15) begin
         // empty or inverted
         lo = $urandom;
         hi = $urandom_range(lo, 0);
      end else if (kind < 45) begin
         lo = $urandom;
         span = $urandom_range(256, 1);
         if (lo > 32'hFFFF_FFFF - span) begin
            lo = 32'hFFFF_FFFF - span;
         end
         hi = lo + span;
      end else if (kind < 70) begin
         lo = $urandom;
         hi = $urandom;
      end else begin
         lo = $urandom_range(255, 0);
         hi = $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);
      end
   endtask

   task automatic test_empty_ranges();
      send_range(32'd0, 32'd0);
      send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_range(32'hFFFF_FFFF, 32'd0);
      send_range(32'd1000, 32'd999);
      send_range(32'h8000_0000, 32'h7FFF_FFFF);
      send_range(32'h1234_5678, 32'h1234_5678);
      send_range(32'hAAAA_AAAA, 32'h5555_5555);
   endtask

   task automatic test_bound_extremes();
      send_range(32'd0, 32'hFFFF_FFFF);
      send_range(32'd0, 32'd1);
      send_range(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_range(32'd0, 32'h8000_0000);
      send_range(32'h7FFF_FFFF, 32'h8000_0000);
      send_range(32'd0, 32'd2);
      send_range(32'h5555_5555, 32'hAAAA_AAAA);
      send_range(32'd1, 32'hFFFF_FFFF);
      send_range(32'd0, 32'd3);
      send_range(32'h0000_FFFF, 32'hFFFF_0000);
      send_range(32'd0, 32'hFFFF_FFFF);
   endtask

   task automatic test_back_to_back();
      word_type lo;
      word_type hi;
      idle_on = 1'b0;
      repeat (250) begin
         pick_range(lo, hi);
         send_range(lo, hi);
      end
      idle_on = 1'b1;
   endtask

   task automatic test_random_ranges();
      word_type lo;
      word_type hi;
      repeat (RandomItems - 250) begin
         pick_range(lo, hi);
         send_range(lo, hi);
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !idle_on || ($urandom_range(99) >= 30);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_values.size() == 0) begin
            $error("random_value: unexpected transfer, actual %h", rsp_tdata);
            error_count++;
         end else begin
            if (rsp_tdata !== expected_values[0]) begin
               $error("random_value: expected %h, actual %h",
                      expected_values[0], rsp_tdata);
               error_count++;
            end
            void'(expected_values.pop_front());
            checked_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("tb_ranged_lcg_random NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      idle_on = 1'b1;
      error_count = 0;
      sent_count = 0;
      empty_count = 0;
      checked_count = 0;
      lcg_state = LcgSeed;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_ranges();
      test_bound_extremes();
      test_back_to_back();
      test_random_ranges();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (expected_values.size() != 0) begin
         $error("random_value: %0d results never arrived", expected_values.size());
         error_count++;
      end

      $display("sent %0d requests (%0d with empty or inverted range), checked %0d results",
               sent_count, empty_count, checked_count);
      $display("covered bound extremes, back-to-back traffic and random stalls on both sides");
      if (error_count == 0) begin
         $display("tb_ranged_lcg_random OK");
      end else begin
         $display("tb_ranged_lcg_random NOT OK");
      end
      $finish;
   end

endmodule
